### src/assert_macros.svh
// Assertion macros shared by the buffer's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A property that must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) else $error(msg);

`endif

### src/tsb_pkg.sv
`default_nettype none

package tsb_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int MAX_EVENT_SIZE = 3;

    localparam int TIME_W  = 32;
    localparam int SIZE_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SIZE     = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNSORTED = 3'd3,
        ST_RANGE    = 3'd4
    } status_code_t;

    // One stored event: 58 bits.
    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [1:0]        ev_size;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic         capture;
        logic         append;
        logic         clear;
        logic         set_code;
        status_code_t code;
        logic         read_idx;
        logic         sort_init;
        logic         key_load;
        logic         shift;
        logic         place;
        logic         next_i;
        logic         sort_done;
        logic         emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t command;
        logic size_bad;
        logic full;
        logic unsorted;
        logic idx_oob;
        logic count_lt2;
        logic time_gt;
        logic j_is_one;
        logic last_i;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### src/tsb_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module tsb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tsb_pkg::dp_stat_t stat,
    output tsb_pkg::dp_cmd_t       cmd
);
    import tsb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT,
        S_KEY,
        S_CMP,
        S_PLACE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.command)
                    CMD_WRITE: begin
                        if (stat.size_bad) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = ST_SIZE;
                            state_next   = S_EMIT;
                        end else if (stat.full) begin
                            cmd.set_code = 1'b1;
                            cmd.code     = ST_FULL;
                            state_next   = S_EMIT;
                        end else begin
                            cmd.append = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_SORT: begin
                        if (!stat.unsorted) begin
                            state_next = S_IDLE;
                        end else if (stat.count_lt2) begin
                            cmd.sort_done = 1'b1;
                            state_next    = S_IDLE;
                        end else begin
                            cmd.sort_init = 1'b1;
                            state_next    = S_KEY;
                        end
                    end
                    CMD_READ: begin
                        cmd.set_code = 1'b1;
                        if (stat.unsorted) begin
                            cmd.code = ST_UNSORTED;
                        end else if (stat.idx_oob) begin
                            cmd.code = ST_RANGE;
                        end else begin
                            cmd.code     = ST_OK;
                            cmd.read_idx = 1'b1;
                        end
                        state_next = S_EMIT;
                    end
                    CMD_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_KEY: begin
                cmd.key_load = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP: begin
                if (stat.time_gt) begin
                    cmd.shift = 1'b1;
                    if (stat.j_is_one) begin
                        state_next = S_PLACE;
                    end
                end else begin
                    cmd.place = 1'b1;
                    if (stat.last_i) begin
                        cmd.sort_done = 1'b1;
                        state_next    = S_IDLE;
                    end else begin
                        cmd.next_i = 1'b1;
                        state_next = S_KEY;
                    end
                end
            end
            S_PLACE: begin
                cmd.place = 1'b1;
                if (stat.last_i) begin
                    cmd.sort_done = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    cmd.next_i = 1'b1;
                    state_next = S_KEY;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_no_append_full, aclk, aresetn, !cmd.append || !stat.full, "append while full")
    `ASSERT_ALWAYS(a_read_legal, aclk, aresetn, !cmd.read_idx || (!stat.unsorted && !stat.idx_oob), "illegal read")
    `ASSERT_ALWAYS(a_emit_free, aclk, aresetn, !cmd.emit || stat.out_free, "emit over pending beat")

endmodule

`default_nettype wire

### src/tsb_dp.sv
`default_nettype none
`include "assert_macros.svh"

module tsb_dp #(
    parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tsb_pkg::dp_cmd_t              cmd,
    output tsb_pkg::dp_stat_t                  stat,
    input  wire logic [1:0]                    in_command,
    input  wire logic [tsb_pkg::TIME_W-1:0]    in_time,
    input  wire logic [tsb_pkg::SIZE_W-1:0]    in_size,
    input  wire logic [tsb_pkg::BYTE_W-1:0]    in_byte0,
    input  wire logic [tsb_pkg::BYTE_W-1:0]    in_byte1,
    input  wire logic [tsb_pkg::BYTE_W-1:0]    in_byte2,
    input  wire logic [tsb_pkg::INDEX_W-1:0]   in_index,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output tsb_pkg::status_code_t              m_status,
    output tsb_pkg::entry_t                    m_entry,
    output logic [tsb_pkg::COUNT_W-1:0]        m_count
);
    import tsb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Captured input item.
    logic [1:0]         cmd_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [BYTE_W-1:0]  byte0_reg;
    logic [BYTE_W-1:0]  byte1_reg;
    logic [BYTE_W-1:0]  byte2_reg;
    logic [INDEX_W-1:0] index_reg;

    // Buffer state.
    entry_t             entry_store_reg [DEPTH];
    entry_t             rdata_reg;
    entry_t             key_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               unsorted_reg;
    logic               unsorted_next;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      i_next;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      j_next;
    status_code_t       code_reg;

    // Output register.
    logic               m_valid_reg;
    logic               m_valid_next;
    status_code_t       m_status_reg;
    entry_t             m_entry_reg;
    logic [COUNT_W-1:0] m_count_reg;

    logic               we;
    logic [AW-1:0]      waddr;
    entry_t             wdata;
    logic               re;
    logic [CW-1:0]      raddr_wide;
    logic [31:0]        count_w;
    logic [31:0]        index_w;
    logic [31:0]        i_w;
    logic [CW-1:0]      i_plus1;
    entry_t             captured;

    assign count_w  = 32'(count_reg);
    assign index_w  = 32'(index_reg);
    assign i_w      = 32'(i_reg);
    assign i_plus1  = i_reg + CW'(1);
    assign captured = '{ev_time: time_reg, ev_size: size_reg[1:0],
                        byte0: byte0_reg, byte1: byte1_reg, byte2: byte2_reg};

    always_comb begin
        stat.command   = cmd_t'(cmd_reg);
        stat.size_bad  = (size_reg > SIZE_W'(MAX_EVENT_SIZE));
        stat.full      = (count_w >= 32'(DEPTH));
        stat.unsorted  = unsorted_reg;
        stat.idx_oob   = (index_w >= count_w);
        stat.count_lt2 = (count_w < 32'd2);
        stat.time_gt   = (rdata_reg.ev_time > key_reg.ev_time);
        stat.j_is_one  = (j_reg == CW'(1));
        stat.last_i    = ((i_w + 32'd1) >= count_w);
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Memory port selection: one write and one read per cycle.
    always_comb begin
        we    = cmd.append || cmd.shift || cmd.place;
        waddr = count_reg[AW-1:0];
        wdata = captured;
        if (cmd.shift) begin
            waddr = j_reg[AW-1:0];
            wdata = rdata_reg;
        end else if (cmd.place) begin
            waddr = j_reg[AW-1:0];
            wdata = key_reg;
        end

        re         = cmd.read_idx || cmd.sort_init || cmd.key_load
                     || cmd.shift || cmd.next_i;
        raddr_wide = i_plus1;
        if (cmd.read_idx) begin
            raddr_wide = index_w[CW-1:0];
        end else if (cmd.sort_init) begin
            raddr_wide = CW'(1);
        end else if (cmd.key_load) begin
            raddr_wide = j_reg - CW'(1);
        end else if (cmd.shift) begin
            raddr_wide = j_reg - CW'(2);
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= entry_store_reg[raddr_wide[AW-1:0]];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.append) begin
            count_next = count_reg + CW'(1);
        end

        unsorted_next = unsorted_reg;
        if (cmd.clear || cmd.sort_done) begin
            unsorted_next = 1'b0;
        end else if (cmd.append) begin
            unsorted_next = 1'b1;
        end

        i_next = i_reg;
        j_next = j_reg;
        if (cmd.sort_init) begin
            i_next = CW'(1);
            j_next = CW'(1);
        end else if (cmd.next_i) begin
            i_next = i_plus1;
            j_next = i_plus1;
        end else if (cmd.shift) begin
            j_next = j_reg - CW'(1);
        end

        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            unsorted_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            unsorted_reg <= unsorted_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;
        j_reg <= j_next;
        if (cmd.capture) begin
            cmd_reg   <= in_command;
            time_reg  <= in_time;
            size_reg  <= in_size;
            byte0_reg <= in_byte0;
            byte1_reg <= in_byte1;
            byte2_reg <= in_byte2;
            index_reg <= in_index;
        end
        if (cmd.key_load) begin
            key_reg <= rdata_reg;
        end
        if (cmd.set_code) begin
            code_reg <= cmd.code;
        end
        if (cmd.emit) begin
            m_status_reg <= code_reg;
            m_entry_reg  <= (code_reg == ST_OK) ? rdata_reg : '0;
            m_count_reg  <= count_w[COUNT_W-1:0];
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_entry  = m_entry_reg;
    assign m_count  = m_count_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_w <= 32'(DEPTH), "count above depth")
    `ASSERT_NEXT(a_clear_empties, aclk, aresetn, cmd.clear, count_reg == '0, "clear left entries")
    `ASSERT_ALWAYS(a_error_zero, aclk, aresetn, !m_valid_reg || m_status_reg == ST_OK || m_entry_reg == '0, "error beat carries data")

endmodule

`default_nettype wire

### src/timestamp_sorting_event_buffer_core.sv
`default_nettype none

// Channel   Direction  tuser                 tdata
// s_        in         [1:0] command         [31:0] event_time, [39:32] event_size,
//                                            [47:40] data_byte0, [55:48] data_byte1,
//                                            [63:56] data_byte2, [69:64] read_index
// m_        out        [2:0] status          [31:0] out_time, [33:32] out_size,
//                                            [41:34] out_byte0, [49:42] out_byte1,
//                                            [57:50] out_byte2, [64:58] event_count
//
// One command beat is handled at a time. A write or clear completes in the decode state, a
// read or a rejected write goes on to the emit state for its result beat. A sort takes each
// stored event from the second on as the key and shifts later-timed ones up one place per step,
// as the event memory has a single read port. Reset clears the count, the unsorted mark and
// the result valid flag; the memory needs no clearing pass. The result register lets a new
// command beat be taken while a result beat still waits on m_tready.

module timestamp_sorting_event_buffer_core #(
    parameter int DEPTH = tsb_pkg::DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // event_time, event_size, data_byte0..2, read_index
    input  wire logic [1:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // out_time, out_size, out_byte0..2, event_count
    output logic [2:0]       m_tuser    // status
);
    import tsb_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    status_code_t       m_status;
    entry_t             m_entry;
    logic [COUNT_W-1:0] m_count;

    // The controller sequences each command; the datapath holds the store and
    // the insertion-sort registers and answers with comparison results.
    tsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_command (s_tuser),
        .in_time    (s_tdata[31:0]),
        .in_size    (s_tdata[39:32]),
        .in_byte0   (s_tdata[47:40]),
        .in_byte1   (s_tdata[55:48]),
        .in_byte2   (s_tdata[63:56]),
        .in_index   (s_tdata[69:64]),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_status   (m_status),
        .m_entry    (m_entry),
        .m_count    (m_count)
    );

    // Result beat packing, upper bits padded with zeros to whole bytes.
    assign m_tuser = m_status;
    assign m_tdata = {7'd0, m_count, m_entry.byte2, m_entry.byte1, m_entry.byte0,
                      m_entry.ev_size, m_entry.ev_time};

endmodule

`default_nettype wire
